### src/intra_dct_quant_dequant_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the intra DCT quantiser/dequantiser
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef INTRA_DCT_QUANT_DEQUANT_TOP_ASSERT_SVH
`define INTRA_DCT_QUANT_DEQUANT_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define IQD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define IQD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/iqd_pkg.sv
// ----------------------------------------------------------------------------
// iqd_pkg
// Stage payload types and the reciprocal table of the quantiser pipeline.
// ----------------------------------------------------------------------------
package iqd_pkg;

	localparam int CoefW  = 12;
	localparam int QuantW = 5;
	localparam int MulAW  = 17;
	localparam int MulBW  = 11;
	localparam int ProdW  = MulAW + MulBW;
	localparam int RecipShift = 16;

	localparam logic ActQuant   = 1'b0;
	localparam logic ActDequant = 1'b1;

	// floor(2^16 / q); entry 0 is never used (a zero step is forced to 1)
	localparam logic [MulAW-1:0] RecipTable [32] = '{
		17'd65536, 17'd65536, 17'd32768, 17'd21845,
		17'd16384, 17'd13107, 17'd10922, 17'd9362,
		17'd8192,  17'd7281,  17'd6553,  17'd5957,
		17'd5461,  17'd5041,  17'd4681,  17'd4369,
		17'd4096,  17'd3855,  17'd3640,  17'd3449,
		17'd3276,  17'd3120,  17'd2978,  17'd2849,
		17'd2730,  17'd2621,  17'd2520,  17'd2427,
		17'd2340,  17'd2259,  17'd2184,  17'd2114
	};

	typedef struct packed {
		logic              action;
		logic              is_dc;
		logic              neg;
		logic [CoefW-1:0]  mag;
		logic [QuantW-1:0] q;
		logic [MulAW-1:0]  mul_a;
		logic [MulBW-1:0]  mul_b;
	} s1_t;

	typedef struct packed {
		logic              action;
		logic              is_dc;
		logic              neg;
		logic [CoefW-1:0]  mag;
		logic [QuantW-1:0] q;
		logic [ProdW-1:0]  prod;
	} s2_t;

	typedef struct packed {
		logic             action;
		logic             is_dc;
		logic             neg;
		logic [CoefW-1:0] mag;
		logic [MulAW-1:0] val;
	} s3_t;

endpackage

### src/iqd_decode.sv
// ----------------------------------------------------------------------------
// iqd_decode
// Stage 1: sign/magnitude split, step fix-up and multiplier operand select.
// ----------------------------------------------------------------------------
module iqd_decode (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        action,
	input  logic                        is_dc,
	input  logic signed [11:0]          coefficient,
	input  logic [4:0]                  quant_step,
	output logic                        valid_s1,
	input  logic                        ready_nxt,
	output iqd_pkg::s1_t                data_s1
);
	import iqd_pkg::*;

	logic              neg;
	logic [CoefW-1:0]  mag;
	logic [QuantW-1:0] q_eff;
	s1_t               nxt;

	assign neg   = coefficient[CoefW-1];
	assign mag   = neg ? (~coefficient + 1'b1) : coefficient;
	assign q_eff = (quant_step == '0) ? QuantW'(1) : quant_step;

	always_comb begin
		nxt.action = action;
		nxt.is_dc  = is_dc;
		nxt.neg    = neg;
		nxt.mag    = mag;
		nxt.q      = q_eff;
		if (action == ActDequant) begin
			nxt.mul_a = MulAW'({mag, 1'b1});
			nxt.mul_b = MulBW'(q_eff);
		end else begin
			nxt.mul_a = RecipTable[q_eff];
			nxt.mul_b = mag[CoefW-1:1];
		end
	end

	assign in_ready = !valid_s1 || ready_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= nxt;
		end
	end

endmodule

### src/iqd_mul.sv
// ----------------------------------------------------------------------------
// iqd_mul
// Stage 2: shared 17x11 multiplier (reciprocal or reconstruction product).
// ----------------------------------------------------------------------------
module iqd_mul (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         valid_s1,
	output logic         ready_o,
	input  iqd_pkg::s1_t data_s1,
	output logic         valid_s2,
	input  logic         ready_nxt,
	output iqd_pkg::s2_t data_s2
);
	import iqd_pkg::*;

	s2_t nxt;

	always_comb begin
		nxt.action = data_s1.action;
		nxt.is_dc  = data_s1.is_dc;
		nxt.neg    = data_s1.neg;
		nxt.mag    = data_s1.mag;
		nxt.q      = data_s1.q;
		nxt.prod   = ProdW'(data_s1.mul_a) * ProdW'(data_s1.mul_b);
	end

	assign ready_o = !valid_s2 || ready_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_o) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_o && valid_s1) begin
			data_s2 <= nxt;
		end
	end

endmodule

### src/iqd_divfix.sv
// ----------------------------------------------------------------------------
// iqd_divfix
// Stage 3: quotient correction for the forward path, even-step fix-up for
// the inverse path.
// ----------------------------------------------------------------------------
module iqd_divfix (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         valid_s2,
	output logic         ready_o,
	input  iqd_pkg::s2_t data_s2,
	output logic         valid_s3,
	input  logic         ready_nxt,
	output iqd_pkg::s3_t data_s3
);
	import iqd_pkg::*;

	logic [MulBW-1:0] est;
	logic [15:0]      chk;
	logic [15:0]      rem;
	logic [MulBW:0]   quo;
	logic [MulAW-1:0] rec;
	s3_t              nxt;

	// estimate is the true quotient or one below it
	assign est = data_s2.prod[RecipShift +: MulBW];
	assign chk = 16'(est) * 16'(data_s2.q);
	assign rem = 16'(data_s2.mag[CoefW-1:1]) - chk;
	assign quo = (rem >= 16'(data_s2.q)) ? ((MulBW+1)'(est) + 1'b1) : (MulBW+1)'(est);

	// even step: drop one from the magnitude
	assign rec = data_s2.prod[MulAW-1:0] - MulAW'(!data_s2.q[0]);

	always_comb begin
		nxt.action = data_s2.action;
		nxt.is_dc  = data_s2.is_dc;
		nxt.neg    = data_s2.neg;
		nxt.mag    = data_s2.mag;
		nxt.val    = (data_s2.action == ActDequant) ? rec : MulAW'(quo);
	end

	assign ready_o = !valid_s3 || ready_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_o) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_o && valid_s2) begin
			data_s3 <= nxt;
		end
	end

endmodule

### src/iqd_clamp.sv
// ----------------------------------------------------------------------------
// iqd_clamp
// Stage 4: DC paths, range clamps and sign restore into the output register.
// ----------------------------------------------------------------------------
`include "intra_dct_quant_dequant_top_assert.svh"

module iqd_clamp (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wide_ac,
	input  logic               valid_s3,
	output logic               ready_o,
	input  iqd_pkg::s3_t       data_s3,
	output logic               valid_s4,
	input  logic               ready_nxt,
	output logic signed [11:0] result_s4
);
	import iqd_pkg::*;

	logic [8:0]        dc_q;
	logic [CoefW:0]    lim;
	logic [CoefW:0]    ac_mag;
	logic [CoefW:0]    ac_neg;
	logic [CoefW-1:0]  nxt;

	assign dc_q = data_s3.mag[CoefW-1:3];

	always_comb begin
		if (data_s3.action == ActDequant) begin
			lim = data_s3.neg ? 13'd2048 : 13'd2047;
		end else if (wide_ac) begin
			lim = data_s3.neg ? 13'd1024 : 13'd1023;
		end else begin
			lim = 13'd127;
		end
	end

	assign ac_mag = (data_s3.val > MulAW'(lim)) ? lim : data_s3.val[CoefW:0];
	assign ac_neg = ~ac_mag + 1'b1;

	always_comb begin
		if (data_s3.action == ActQuant) begin
			if (data_s3.is_dc) begin
				if (data_s3.neg || dc_q == '0) begin
					nxt = 12'd1;
				end else if (dc_q > 9'd255) begin
					nxt = 12'd255;
				end else begin
					nxt = 12'(dc_q);
				end
			end else begin
				nxt = data_s3.neg ? ac_neg[CoefW-1:0] : ac_mag[CoefW-1:0];
			end
		end else begin
			if (data_s3.is_dc) begin
				if (data_s3.neg) begin
					nxt = 12'd0;
				end else if (data_s3.mag >= 12'd256) begin
					nxt = 12'd2047;
				end else begin
					nxt = {data_s3.mag[8:0], 3'b000};
				end
			end else if (data_s3.mag == '0) begin
				nxt = 12'd0;
			end else begin
				nxt = data_s3.neg ? ac_neg[CoefW-1:0] : ac_mag[CoefW-1:0];
			end
		end
	end

	assign ready_o = !valid_s4 || ready_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (ready_o) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_o && valid_s3) begin
			result_s4 <= nxt;
		end
	end

	`IQD_ASSERT_NOW(a_quot_bound,
		valid_s3 && data_s3.action == ActQuant && !data_s3.is_dc,
		data_s3.val <= 17'd1024, "forward AC quotient above 1024")
	`IQD_ASSERT_NEXT(a_fwd_dc_range,
		valid_s3 && ready_o && data_s3.action == ActQuant && data_s3.is_dc,
		result_s4 >= 12'sd1 && result_s4 <= 12'sd255, "forward DC level outside 1..255")
	`IQD_ASSERT_NEXT(a_inv_dc_sign,
		valid_s3 && ready_o && data_s3.action == ActDequant && data_s3.is_dc,
		!result_s4[11], "reconstructed DC is negative")
	`IQD_ASSERT_NEXT(a_narrow_ac,
		valid_s3 && ready_o && data_s3.action == ActQuant && !data_s3.is_dc && !wide_ac,
		result_s4 >= -12'sd127 && result_s4 <= 12'sd127, "narrow AC level outside +-127")

endmodule

### src/intra_dct_quant_dequant_top.sv
// ----------------------------------------------------------------------------
// intra_dct_quant_dequant_top
// H.263 intra quantiser / inverse quantiser, one coefficient per beat.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+----------------------------------
//   in      | input     | in_valid / in_ready   | action, is_dc, coefficient, quant_step
//   out     | output    | out_valid / out_ready | result_value
//   cfg     | input     | cfg_valid / cfg_ready | cfg_data (wide_ac_range)
//
// One beat per cycle is sustained while out_ready is high, set by the
// four register stages with one multiplier in stage 2.
// Reset clears the stage valid bits and wide_ac_range; no clearing pass.
// A stall on out backs up stage by stage: each stage takes a new beat when it
// is empty or its successor advances, so bubbles are filled during a stall.
// cfg_ready is always high; the register takes effect at the clamp stage.
// ----------------------------------------------------------------------------
module intra_dct_quant_dequant_top (
	input  logic               clk,
	input  logic               arst_n,
	// input coefficients / levels
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               action,
	input  logic               is_dc,
	input  logic signed [11:0] coefficient,
	input  logic [4:0]         quant_step,
	// results
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [11:0] result_value,
	// configuration
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_data
);
	import iqd_pkg::*;

	logic wide_ac_range_q;

	logic valid_s1, valid_s2, valid_s3;
	logic rdy_s2, rdy_s3, rdy_s4;
	s1_t  data_s1;
	s2_t  data_s2;
	s3_t  data_s3;

	// Configuration: always accept, hold the Annex T range select.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wide_ac_range_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			wide_ac_range_q <= cfg_data;
		end
	end

	// Stage 1: split sign and magnitude, pick multiplier operands.
	iqd_decode u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.is_dc       (is_dc),
		.coefficient (coefficient),
		.quant_step  (quant_step),
		.valid_s1    (valid_s1),
		.ready_nxt   (rdy_s2),
		.data_s1     (data_s1)
	);

	// Stage 2: reciprocal multiply (forward) or q*(2|L|+1) (inverse).
	iqd_mul u_mul (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.ready_o   (rdy_s2),
		.data_s1   (data_s1),
		.valid_s2  (valid_s2),
		.ready_nxt (rdy_s3),
		.data_s2   (data_s2)
	);

	// Stage 3: correct the quotient estimate, apply the even-step adjust.
	iqd_divfix u_divfix (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s2  (valid_s2),
		.ready_o   (rdy_s3),
		.data_s2   (data_s2),
		.valid_s3  (valid_s3),
		.ready_nxt (rdy_s4),
		.data_s3   (data_s3)
	);

	// Stage 4: DC handling, clamps and sign restore; doubles as output register.
	iqd_clamp u_clamp (
		.clk       (clk),
		.arst_n    (arst_n),
		.wide_ac   (wide_ac_range_q),
		.valid_s3  (valid_s3),
		.ready_o   (rdy_s4),
		.data_s3   (data_s3),
		.valid_s4  (out_valid),
		.ready_nxt (out_ready),
		.result_s4 (result_value)
	);

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the H.263 intra quantiser / inverse quantiser.
// A queue-fed driver pushes coefficient beats with random gaps while the
// monitor stalls the result side at random, predicts every accepted beat and
// compares each result beat in order. The range register is switched between
// phases only while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import iqd_pkg::*;

	localparam int CycleLimit  = 1000000;
	localparam int PhaseItems  = 300;
	localparam int PhaseCount  = 6;
	localparam int DrainCycles = 8;

	// one coefficient beat waiting to be sent
	typedef struct {
		logic                     act;
		logic                     dc;
		logic signed [CoefW-1:0]  coef;
		logic [QuantW-1:0]        qs;
		bit                       drain_first;
	} coef_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic                     action = ActQuant;
	logic                     is_dc = 1'b0;
	logic signed [CoefW-1:0]  coefficient = '0;
	logic [QuantW-1:0]        quant_step = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic signed [CoefW-1:0]  result_value;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic                     cfg_data = 1'b0;

	coef_item_t              pending_items[$];
	logic signed [CoefW-1:0] level_expected[$];

	// shadow of the range register, as seen by the predictor
	logic range_wide = 1'b0;

	int sent_count = 0;
	int received_count = 0;
	int error_count = 0;
	int cycle_count = 0;

	int in_gap_left = 0;
	int in_burst_left = 0;
	int out_stall_left = 0;
	int out_burst_left = 0;

	intra_dct_quant_dequant_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.is_dc        (is_dc),
		.coefficient  (coefficient),
		.quant_step   (quant_step),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_value (result_value),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------
	function automatic int clamp_to(int v, int lo, int hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// Compute the level or reconstructed coefficient for one beat.
	function automatic logic signed [CoefW-1:0] quantize_coef(logic act, logic dc,
			logic signed [CoefW-1:0] coef, logic [QuantW-1:0] qs, logic wide);
		int c;
		int q;
		int mag;
		int rec;
		int r;
		c = coef;
		// a zero step is out of range; treat it as a step of one
		q = (qs == 0) ? 1 : int'(qs);
		if (act == ActQuant) begin
			if (dc) begin
				r = clamp_to(c / 8, 1, 255);
			end else if (wide) begin
				r = clamp_to(c / (2 * q), -1024, 1023);
			end else begin
				r = clamp_to(c / (2 * q), -127, 127);
			end
		end else begin
			if (dc) begin
				r = clamp_to(c * 8, 0, 2047);
			end else if (c == 0) begin
				r = 0;
			end else begin
				mag = (c < 0) ? -c : c;
				rec = q * (2 * mag + 1);
				// even steps pull the magnitude down by one
				if (q[0] == 1'b0)
					rec = rec - 1;
				if (c < 0)
					rec = -rec;
				r = clamp_to(rec, -2048, 2047);
			end
		end
		return r[CoefW-1:0];
	endfunction

	// ------------------------------------------------------------------
	// Random helpers
	// ------------------------------------------------------------------
	// Gap length: mostly none or short, a few long, with runs of no gaps.
	function automatic int next_gap(inout int burst_left);
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			burst_left = $urandom_range(30, 120);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic signed [CoefW-1:0] pick_coef();
		int r;
		int v;
		r = $urandom_range(0, 99);
		if (r < 45)
			v = $urandom;
		else if (r < 75)
			v = $urandom_range(0, 128) - 64;
		else if (r < 88)
			v = 2047 - $urandom_range(0, 15);
		else
			v = -2048 + $urandom_range(0, 15);
		return v[CoefW-1:0];
	endfunction

	function automatic logic [QuantW-1:0] pick_quant();
		int r;
		r = $urandom_range(0, 99);
		if (r < 6)
			return '0;
		if (r < 12)
			return 5'd31;
		if (r < 18)
			return 5'd1;
		return QuantW'($urandom_range(1, 31));
	endfunction

	function automatic void queue_item(logic act, logic dc, int coef, int qs, bit drain);
		coef_item_t item;
		item.act = act;
		item.dc = dc;
		item.coef = coef[CoefW-1:0];
		item.qs = qs[QuantW-1:0];
		item.drain_first = drain;
		pending_items.push_back(item);
	endfunction

	// ------------------------------------------------------------------
	// Driver: present queued beats, hold each until accepted, then idle
	// ------------------------------------------------------------------
	always @(posedge clk) begin : feed_proc
		coef_item_t nxt;
		bit took;
		if (arst_n) begin
			took = in_valid && in_ready;
			if (took)
				sent_count++;
			if (in_valid && !took) begin
				// hold valid and payload until the beat goes through
			end else if (in_gap_left > 0) begin
				in_gap_left--;
				in_valid <= 1'b0;
			end else if (pending_items.size() != 0 && (!pending_items[0].drain_first ||
					sent_count == received_count)) begin
				// a drain-first beat waits until every result is back
				nxt = pending_items.pop_front();
				in_valid    <= 1'b1;
				action      <= nxt.act;
				is_dc       <= nxt.dc;
				coefficient <= nxt.coef;
				quant_step  <= nxt.qs;
				in_gap_left = next_gap(in_burst_left);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: track the register, predict accepted beats, check results
	// ------------------------------------------------------------------
	always @(posedge clk) begin : watch_proc
		logic signed [CoefW-1:0] want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				range_wide = cfg_data;
			if (in_valid && in_ready)
				level_expected.push_back(quantize_coef(action, is_dc, coefficient,
					quant_step, range_wide));
			if (out_valid && out_ready) begin
				received_count++;
				if (level_expected.size() == 0) begin
					$error("result_value: no beat expected, actual %0d", result_value);
					error_count++;
				end else begin
					want = level_expected.pop_front();
					if (result_value !== want) begin
						$error("result_value: expected %0d, actual %0d", want, result_value);
						error_count++;
					end
				end
			end
			// stall the result side at random
			if (out_stall_left > 0) begin
				out_stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				out_stall_left = next_gap(out_burst_left);
			end
		end
	end

	// ------------------------------------------------------------------
	// Sequencing
	// ------------------------------------------------------------------
	// Wait until nothing is queued, in flight or outstanding.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_items.size() != 0 || in_valid || sent_count != received_count);
	endtask

	task automatic write_range_cfg(input logic val);
		wait_idle();
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus_proc
		logic wide_plan [PhaseCount];
		wide_plan = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};

		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// narrow range: extremes, truncation, clamps, zero step
		write_range_cfg(1'b0);
		queue_item(ActQuant, 1'b1, 2047, 5, 1'b0);
		queue_item(ActQuant, 1'b1, -2048, 5, 1'b0);
		queue_item(ActQuant, 1'b1, 0, 1, 1'b0);
		queue_item(ActQuant, 1'b1, 15, 31, 1'b0);
		queue_item(ActQuant, 1'b1, 16, 0, 1'b0);
		queue_item(ActQuant, 1'b0, 2047, 1, 1'b0);
		queue_item(ActQuant, 1'b0, -2048, 1, 1'b0);
		queue_item(ActQuant, 1'b0, -2048, 31, 1'b0);
		queue_item(ActQuant, 1'b0, 61, 31, 1'b0);
		queue_item(ActQuant, 1'b0, -7, 0, 1'b0);
		queue_item(ActDequant, 1'b1, 0, 9, 1'b0);
		queue_item(ActDequant, 1'b1, 255, 9, 1'b0);
		queue_item(ActDequant, 1'b1, 256, 9, 1'b0);
		queue_item(ActDequant, 1'b1, -1, 9, 1'b0);
		queue_item(ActDequant, 1'b0, 0, 7, 1'b0);
		queue_item(ActDequant, 1'b0, 1, 1, 1'b0);
		queue_item(ActDequant, 1'b0, -1, 2, 1'b0);
		queue_item(ActDequant, 1'b0, 2047, 31, 1'b0);
		queue_item(ActDequant, 1'b0, -2048, 30, 1'b0);
		queue_item(ActDequant, 1'b0, 3, 0, 1'b0);

		// wide range: the Annex T clamps
		write_range_cfg(1'b1);
		queue_item(ActQuant, 1'b0, 2047, 1, 1'b0);
		queue_item(ActQuant, 1'b0, -2048, 1, 1'b0);
		queue_item(ActQuant, 1'b0, 2047, 31, 1'b0);
		queue_item(ActQuant, 1'b0, -300, 2, 1'b0);

		// random phases; the mid-phase beat and some random beats drain the pipeline first
		for (int p = 0; p < PhaseCount; p++) begin
			write_range_cfg(wide_plan[p]);
			for (int k = 0; k < PhaseItems; k++) begin
				queue_item(logic'($urandom_range(0, 1)), ($urandom_range(0, 3) == 0),
					int'(pick_coef()), int'(pick_quant()),
					(k == PhaseItems / 2) || ($urandom_range(0, 99) == 0));
			end
		end

		wait_idle();
		repeat (DrainCycles) @(posedge clk);
		if (level_expected.size() != 0) begin
			$error("result_value: %0d beats never arrived", level_expected.size());
			error_count++;
		end
		if (error_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// Abort a hung run.
	initial begin : watchdog_proc
		while (cycle_count < CycleLimit)
			@(posedge clk);
		$display("CHECK FAILED");
		$finish;
	end

endmodule
